>>> src/no_repeat_random_track_picker_assert.svh
// assertion macros for the track picker rtl
// needs clk and arst_n in the scope where a macro is used
`ifndef NO_REPEAT_RANDOM_TRACK_PICKER_ASSERT_SVH
`define NO_REPEAT_RANDOM_TRACK_PICKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NRRTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrrtp same-cycle check failed");

// antecedent implies consequent in the following cycle
`define NRRTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrrtp next-cycle check failed");

`endif

>>> src/nrrtp_pkg.sv
// shared types and constants for the no-repeat random track picker
// no dependencies
package nrrtp_pkg;

	localparam int unsigned MAX_TRACKS  = 256;
	localparam int unsigned INDEX_LIMIT = 256;
	localparam int unsigned CNT_LIMIT   = (MAX_TRACKS < INDEX_LIMIT) ? MAX_TRACKS : INDEX_LIMIT;

	localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
	localparam logic [31:0] ZERO_ESCAPE = 32'h9e3779b9;

	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_FOLD    = 2'd1;
	localparam logic [1:0] OP_DRAW    = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] seed_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] track_index;
		logic       no_tracks;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [8:0]  divisor;
		logic [5:0]  nbits;
	} rem_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] rem;
	} rem_rsp_t;

endpackage

>>> src/nrrtp_rem.sv
// iterative remainder unit, one dividend bit per cycle, msb first
// depends on nrrtp_pkg
module nrrtp_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  nrrtp_pkg::rem_req_t req,
	output nrrtp_pkg::rem_rsp_t rsp
);
	import nrrtp_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [8:0]  div_q;
	logic [7:0]  rem_q;
	logic [8:0]  trial;
	logic [7:0]  rem_next;

	assign trial    = {rem_q, dvd_q[31]};
	assign rem_next = (trial >= div_q) ? 8'(trial - div_q) : trial[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = busy_q && (cnt_q == 6'd1);
	assign rsp.rem  = rem_next;

endmodule

>>> src/no_repeat_random_track_picker.sv
// top level of the no-repeat random track picker
// depends on nrrtp_pkg, nrrtp_rem and no_repeat_random_track_picker_assert.svh
//
// Restart and seed-byte requests are handled in ST_IDLE and give no result. A draw
// request gives one result. With no tracks, as the first pick, or with a single
// track, the draw goes from ST_PREP straight to ST_DONE. Otherwise it runs the shared
// one-bit-per-cycle remainder unit twice (32 steps for the random value modulo
// count minus one, then 9 steps for the index wrap) in ST_MOD1 and ST_MOD2 before
// ST_DONE. In either case ST_DONE hands the result to the output register and the
// next request can be taken once that is done. item_stall is high while a draw is
// in progress and while a finished draw waits for the result register to free up.
module no_repeat_random_track_picker #(
	parameter int unsigned MAX_TRACKS = nrrtp_pkg::MAX_TRACKS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [8:0]          wr_data,
	input  logic                item_valid,
	output logic                item_stall,
	input  nrrtp_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output nrrtp_pkg::result_t  result
);
	import nrrtp_pkg::*;

	`include "no_repeat_random_track_picker_assert.svh"

	localparam int unsigned CNT_MAX = (MAX_TRACKS < INDEX_LIMIT) ? MAX_TRACKS : INDEX_LIMIT;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MOD1 = 3'd2;
	localparam logic [2:0] ST_MOD2 = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]  state_q;
	logic [8:0]  count_q;
	logic [31:0] shuffle_q;
	logic        first_q;
	logic [7:0]  last_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_valid_q;

	logic        accept;
	logic [8:0]  cnt;
	logic [31:0] fnv_x;
	logic [31:0] fnv_next;
	logic [31:0] xs_a;
	logic [31:0] xs_b;
	logic [31:0] xs_c;
	logic [31:0] xs_next;
	logic [8:0]  sum;
	logic        out_free;
	rem_req_t    u_req;
	rem_rsp_t    u_rsp;

	nrrtp_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.rsp    (u_rsp)
	);

	assign accept   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign cnt      = (count_q > 9'(CNT_MAX)) ? 9'(CNT_MAX) : count_q;

	// fnv-1a fold, prime 2^24 + 0x193 as shift-add
	assign fnv_x    = shuffle_q ^ {24'd0, item.seed_byte};
	assign fnv_next = (fnv_x << 24) + (fnv_x << 8) + (fnv_x << 7) + (fnv_x << 4)
		+ (fnv_x << 1) + fnv_x;

	assign xs_a    = (shuffle_q == 32'd0) ? ZERO_ESCAPE : shuffle_q;
	assign xs_b    = xs_a ^ (xs_a << 13);
	assign xs_c    = xs_b ^ (xs_b >> 17);
	assign xs_next = xs_c ^ (xs_c << 5);

	assign sum = 9'(last_q) + 9'd1 + 9'(u_rsp.rem);

	always_comb begin
		u_req = '0;
		if (state_q == ST_PREP) begin
			u_req.start    = (cnt > 9'd1) && !first_q;
			u_req.dividend = xs_next;
			u_req.divisor  = cnt - 9'd1;
			u_req.nbits    = 6'd32;
		end else if (state_q == ST_MOD1) begin
			u_req.start    = u_rsp.done;
			u_req.dividend = {sum, 23'd0};
			u_req.divisor  = cnt;
			u_req.nbits    = 6'd9;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			shuffle_q   <= FNV_BASIS;
			first_q     <= 1'b1;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= wr_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_RESTART: begin
								shuffle_q <= FNV_BASIS;
								first_q   <= 1'b1;
								last_q    <= '0;
							end
							OP_FOLD: shuffle_q <= fnv_next;
							OP_DRAW: state_q   <= ST_PREP;
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					if (cnt == 9'd0) begin
						state_q <= ST_DONE;
					end else if (first_q) begin
						first_q <= 1'b0;
						last_q  <= '0;
						state_q <= ST_DONE;
					end else if (cnt == 9'd1) begin
						last_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						shuffle_q <= xs_next;
						state_q   <= ST_MOD1;
					end
				end
				ST_MOD1: begin
					if (u_rsp.done) begin
						state_q <= ST_MOD2;
					end
				end
				ST_MOD2: begin
					if (u_rsp.done) begin
						last_q  <= u_rsp.rem;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			res_q.track_index <= '0;
			res_q.no_tracks   <= (cnt == 9'd0);
		end else if (state_q == ST_MOD2 && u_rsp.done) begin
			res_q.track_index <= u_rsp.rem;
			res_q.no_tracks   <= 1'b0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`NRRTP_ASSERT_NOW(a_unit_done_in_mod, u_rsp.done, (state_q == ST_MOD1) || (state_q == ST_MOD2))
	`NRRTP_ASSERT_NOW(a_index_in_range, (state_q == ST_MOD2) && u_rsp.done, 9'(u_rsp.rem) < cnt)
	`NRRTP_ASSERT_NEXT(a_result_from_done, !out_valid_q && (state_q != ST_DONE), !out_valid_q)
	`NRRTP_ASSERT_NEXT(a_first_clear_only_in_prep, first_q && (state_q != ST_PREP) && !accept, first_q)

endmodule

>>> tb/sv/tb_no_repeat_random_track_picker.sv
// self-checking testbench for no_repeat_random_track_picker: directed table, then random requests
// predicts picks by an fnv-1a/xorshift32 model or fixed table value; checks each result in order
// depends on nrrtp_pkg and the rtl of the block
module tb_no_repeat_random_track_picker;
	timeunit 1ns;
	timeprecision 1ps;
	import nrrtp_pkg::*;

	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		item_t req;
		logic fixed;
		result_t want;
	} pending_t;

	typedef struct packed {
		logic set_cnt;
		logic [8:0] cnt;
		pending_t p;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [8:0] wr_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	no_repeat_random_track_picker uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #2 clk = ~clk;

	logic [31:0] shuf_state = FNV_BASIS;
	logic first_pick = 1'b1;
	int unsigned last_idx = 0;
	logic [8:0] track_cnt = '0;

	pending_t req_q[$];
	result_t pick_q[$];
	int send_idle = 7;
	int recv_idle = 86;
	int n_err = 0;
	int n_req = 0;
	int n_pick = 0;
	int n_empty = 0;
	int n_zero = 0;
	int cycles = 0;

	function automatic logic [31:0] fnv_fold(input logic [31:0] s, input logic [7:0] b);
		return (s ^ {24'd0, b}) * FNV_PRIME;
	endfunction

	function automatic void predict_pick(input item_t req, output logic has, output result_t res);
		int unsigned cnt;
		logic [31:0] s;
		has = 1'b0;
		res = '0;
		case (req.op)
			OP_RESTART: begin
				shuf_state = FNV_BASIS;
				first_pick = 1'b1;
				last_idx = 0;
			end
			OP_FOLD: shuf_state = fnv_fold(shuf_state, req.seed_byte);
			OP_DRAW: begin
				has = 1'b1;
				cnt = (track_cnt > CNT_LIMIT) ? CNT_LIMIT : track_cnt;
				if (cnt == 0) begin
					res.no_tracks = 1'b1;
					n_empty++;
				end else begin
					if (first_pick) begin
						first_pick = 1'b0;
						last_idx = 0;
					end else if (cnt > 1) begin
						if (shuf_state == 0)
							n_zero++;
						s = (shuf_state == 0) ? ZERO_ESCAPE : shuf_state;
						s ^= s << 13;
						s ^= s >> 17;
						s ^= s << 5;
						shuf_state = s;
						last_idx = (last_idx + 1 + s % (cnt - 1)) % cnt;
					end else begin
						last_idx = 0;
					end
					res.track_index = last_idx[7:0];
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		pending_t cur;
		logic has;
		result_t res;
		logic go;
		if (item_valid && !item_stall) begin
			cur = req_q.pop_front();
			predict_pick(cur.req, has, res);
			n_req++;
			if (has)
				pick_q.push_back(cur.fixed ? cur.want : res);
		end
		if (!item_valid || !item_stall) begin
			go = (req_q.size() != 0) && ($urandom_range(99, 0) >= send_idle);
			item_valid <= go;
			if (go)
				item <= req_q[0].req;
		end
	end

	always @(posedge clk) begin
		result_t exp_pick;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pick_q.size() == 0) begin
					$display("%0t unexpected pick: expected none, got index %0d no_tracks %0b",
						$time, result.track_index, result.no_tracks);
					n_err++;
				end else begin
					exp_pick = pick_q.pop_front();
					n_pick++;
					if (result.track_index !== exp_pick.track_index) begin
						$display("%0t track_index mismatch: expected %0d, got %0d",
							$time, exp_pick.track_index, result.track_index);
						n_err++;
					end
					if (result.no_tracks !== exp_pick.no_tracks) begin
						$display("%0t no_tracks mismatch: expected %0b, got %0b",
							$time, exp_pick.no_tracks, result.no_tracks);
						n_err++;
					end
				end
			end
			result_stall <= ($urandom_range(99, 0) < recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d picks still pending", cycles, pick_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void queue_req(input logic [1:0] op, input logic [7:0] b);
		pending_t p;
		p = '0;
		p.req.op = op;
		p.req.seed_byte = b;
		req_q.push_back(p);
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (req_q.size() != 0 || item_valid || pick_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [8:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		track_cnt = v;
	endtask

	initial begin
		logic [31:0] inv;
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] s3;
		logic [15:0] zero_tail[logic [31:0]];
		logic [7:0] zb[5];
		logic found;
		dir_row_t dir_tab[24];
		logic [8:0] extremes[7];
		logic [8:0] new_cnt;
		int n_items;

		// byte path from a restart that folds the shuffle state down to zero
		inv = FNV_PRIME;
		repeat (5) inv = inv * (32'd2 - FNV_PRIME * inv);
		for (int y = 0; y < 256; y++)
			for (int b = 0; b < 256; b++)
				zero_tail[(32'(y) * inv) ^ 32'(b)] = {8'(b), 8'(y)};
		found = 1'b0;
		foreach (zb[k]) zb[k] = '0;
		for (int b1 = 0; b1 < 256 && !found; b1++) begin
			s1 = fnv_fold(FNV_BASIS, 8'(b1));
			for (int b2 = 0; b2 < 256 && !found; b2++) begin
				s2 = fnv_fold(s1, 8'(b2));
				for (int b3 = 0; b3 < 256 && !found; b3++) begin
					s3 = fnv_fold(s2, 8'(b3));
					if (zero_tail.exists(s3)) begin
						found = 1'b1;
						zb[0] = 8'(b1);
						zb[1] = 8'(b2);
						zb[2] = 8'(b3);
						zb[3] = zero_tail[s3][15:8];
						zb[4] = zero_tail[s3][7:0];
					end
				end
			end
		end

		dir_tab[0]  = {1'b0, 9'd0,   OP_DRAW,    8'h00, 1'b1, 8'd0, 1'b1};
		dir_tab[1]  = {1'b0, 9'd0,   OP_UNUSED,  8'hff, 1'b0, 8'd0, 1'b0};
		dir_tab[2]  = {1'b1, 9'd1,   OP_DRAW,    8'h00, 1'b1, 8'd0, 1'b0};
		dir_tab[3]  = {1'b0, 9'd0,   OP_DRAW,    8'h5a, 1'b1, 8'd0, 1'b0};
		dir_tab[4]  = {1'b1, 9'd256, OP_RESTART, 8'ha5, 1'b0, 8'd0, 1'b0};
		dir_tab[5]  = {1'b0, 9'd0,   OP_DRAW,    8'h00, 1'b1, 8'd0, 1'b0};
		dir_tab[6]  = {1'b0, 9'd0,   OP_DRAW,    8'hff, 1'b0, 8'd0, 1'b0};
		dir_tab[7]  = {1'b0, 9'd0,   OP_FOLD,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[8]  = {1'b0, 9'd0,   OP_FOLD,    8'hff, 1'b0, 8'd0, 1'b0};
		dir_tab[9]  = {1'b0, 9'd0,   OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[10] = {1'b1, 9'd511, OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[11] = {1'b1, 9'd3,   OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[12] = {1'b1, 9'd2,   OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[13] = {1'b0, 9'd0,   OP_RESTART, 8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[14] = {1'b0, 9'd0,   OP_DRAW,    8'h00, 1'b1, 8'd0, 1'b0};
		for (int k = 0; k < 5; k++)
			dir_tab[15 + k] = {1'b0, 9'd0, OP_FOLD, zb[k], 1'b0, 8'd0, 1'b0};
		dir_tab[20] = {1'b1, 9'd256, OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[21] = {1'b1, 9'd0,   OP_DRAW,    8'h00, 1'b1, 8'd0, 1'b1};
		dir_tab[22] = {1'b1, 9'd255, OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};
		dir_tab[23] = {1'b0, 9'd0,   OP_DRAW,    8'h00, 1'b0, 8'd0, 1'b0};

		extremes = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_cnt) begin
				wait_idle();
				write_count(dir_tab[i].cnt);
			end
			req_q.push_back(dir_tab[i].p);
		end

		for (int ph = 0; ph < 3; ph++) begin
			for (int ch = 0; ch < 6; ch++) begin
				wait_idle();
				send_idle = (ph == 0) ? 7 : (ph == 1) ? 86 : 0;
				recv_idle = (ph == 0) ? 86 : (ph == 1) ? 7 : 0;
				if ($urandom_range(2, 0) == 0)
					new_cnt = extremes[$urandom_range(6, 0)];
				else
					new_cnt = 9'($urandom_range(256, 1));
				write_count(new_cnt);
				n_items = 0;
				while (n_items < 68) begin
					if ($urandom_range(9, 0) == 0) begin
						queue_req(OP_UNUSED, 8'($urandom));
					end else begin
						if ($urandom_range(9, 0) < 7) begin
							queue_req(OP_RESTART, 8'($urandom));
							n_items++;
						end
						repeat ($urandom_range(6, 0)) begin
							queue_req(OP_FOLD, 8'($urandom));
							n_items++;
						end
						repeat ($urandom_range(5, 1)) begin
							queue_req(OP_DRAW, 8'($urandom));
							n_items++;
						end
					end
				end
			end
		end

		wait_idle();
		$display("covered %0d requests and %0d checked picks over counts 0 to 511", n_req, n_pick);
		$display("%0d picks on an empty playlist, %0d from a zero shuffle state", n_empty, n_zero);
		if (n_err == 0 && pick_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d errors, %0d picks never arrived", n_err, pick_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
